FILE: rtl/smpq_pkg.sv
`default_nettype none
package smpq_pkg;

    localparam int DEPTH = 64;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CAP_W = 7;
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int FILL_W = 7;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [0:0] REG_CAPACITY = 1'b0;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic               op;
        logic signed [31:0] value;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] out_value;
        t_status            status;
        logic [FILL_W-1:0]  fill_count;
    } t_out_word;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic               ins;
        logic               rem;
        logic signed [31:0] value;
    } t_cell_ctl;

endpackage
`default_nettype wire

FILE: rtl/smpq_cell.sv
`default_nettype none
module smpq_cell (
    input  wire                 i_clk,
    input  smpq_pkg::t_cell_ctl i_ctl,
    input  wire                 i_occ,
    input  wire                 i_prev_gt,
    input  wire signed [31:0]   i_prev_entry,
    input  wire signed [31:0]   i_next_entry,
    output logic signed [31:0]  o_entry,
    output logic                o_gt
);

    logic signed [31:0] r_entry;
    logic signed [31:0] n_entry;

    assign o_entry = r_entry;
    // strict compare keeps equal values in arrival order
    assign o_gt = i_occ && (r_entry > i_ctl.value);

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (i_prev_gt) begin
                n_entry = i_prev_entry;
            end else if (o_gt || !i_occ) begin
                n_entry = i_ctl.value;
            end
        end else if (i_ctl.rem) begin
            n_entry = i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule
`default_nettype wire

FILE: rtl/sorted_min_priority_queue.sv
// A result word is registered and appears in the cycle after its input word is accepted.
// Throughput: one insert or remove per cycle while the output is not stalled; every cell
// of the sorted chain shifts or loads in the same cycle, so no item waits on another.
// Reset (synchronous, active low): fill count cleared, capacity set to 64,
// output register emptied. Cell contents are not cleared.
`default_nettype none
module sorted_min_priority_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  smpq_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output smpq_pkg::t_out_word  o_out_word,
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire  [2:0]           paddr,
    input  wire  [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [smpq_pkg::CNT_W-1:0] r_count;
    logic [smpq_pkg::CNT_W-1:0] n_count;
    logic [smpq_pkg::CAP_W-1:0] r_capacity;
    logic                       r_out_valid;
    smpq_pkg::t_out_word        r_out_word;
    smpq_pkg::t_out_word        n_out_word;

    smpq_pkg::t_cell_ctl        ctl;
    logic                       accept;
    logic                       full;
    logic                       empty;

    logic signed [31:0]         entry [smpq_pkg::DEPTH];
    logic                       gt    [smpq_pkg::DEPTH];
    logic                       occ   [smpq_pkg::DEPTH];

    assign pready = 1'b1;
    assign prdata = {{(32 - smpq_pkg::CAP_W){1'b0}}, r_capacity};

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign full  = (smpq_pkg::CMP_W'(r_count) >= smpq_pkg::CMP_W'(r_capacity))
                || (smpq_pkg::CMP_W'(r_count) >= smpq_pkg::CMP_W'(smpq_pkg::DEPTH));
    assign empty = (r_count == '0);

    assign ctl.ins   = accept && (i_in_word.op == smpq_pkg::OP_INSERT) && !full;
    assign ctl.rem   = accept && (i_in_word.op == smpq_pkg::OP_REMOVE) && !empty;
    assign ctl.value = i_in_word.value;

    genvar g;
    generate
        for (g = 0; g < smpq_pkg::DEPTH; g++) begin : g_cell
            logic               prev_gt;
            logic signed [31:0] prev_entry;
            logic signed [31:0] next_entry;

            assign occ[g] = smpq_pkg::CNT_W'(g) < r_count;

            if (g == 0) begin : g_head
                assign prev_gt    = 1'b0;
                assign prev_entry = entry[g];
            end else begin : g_body
                assign prev_gt    = gt[g-1];
                assign prev_entry = entry[g-1];
            end

            if (g == smpq_pkg::DEPTH - 1) begin : g_tail
                assign next_entry = entry[g];
            end else begin : g_link
                assign next_entry = entry[g+1];
            end

            smpq_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (ctl),
                .i_occ        (occ[g]),
                .i_prev_gt    (prev_gt),
                .i_prev_entry (prev_entry),
                .i_next_entry (next_entry),
                .o_entry      (entry[g]),
                .o_gt         (gt[g])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (ctl.ins) begin
            n_count = r_count + 1'b1;
        end else if (ctl.rem) begin
            n_count = r_count - 1'b1;
        end
    end

    always_comb begin
        n_out_word.out_value  = '0;
        n_out_word.status     = smpq_pkg::ST_DONE;
        n_out_word.fill_count = smpq_pkg::FILL_W'(n_count);
        if (i_in_word.op == smpq_pkg::OP_INSERT) begin
            if (full) begin
                n_out_word.status = smpq_pkg::ST_FULL;
            end
        end else begin
            if (empty) begin
                n_out_word.status = smpq_pkg::ST_EMPTY;
            end else begin
                n_out_word.out_value = entry[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_capacity  <= smpq_pkg::CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (psel && penable && pwrite && (paddr[2] == smpq_pkg::REG_CAPACITY)) begin
                r_capacity <= pwdata[smpq_pkg::CAP_W-1:0];
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_word <= n_out_word;
        end
    end

endmodule
`default_nettype wire

FILE: tb/smpq_checker.sv
module smpq_checker
    import smpq_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    input  wire         i_in_stall,
    input  t_in_word    i_in_word,
    input  wire         i_out_valid,
    input  wire         i_out_stall,
    input  t_out_word   i_out_word,
    input  wire         i_psel,
    input  wire         i_penable,
    input  wire         i_pwrite,
    input  wire         i_pready,
    input  wire  [2:0]  i_paddr,
    input  wire  [31:0] i_pwdata,
    output int          o_mismatches,
    output int          o_pending,
    output int          o_full_refusals,
    output int          o_empty_refusals
);

    logic signed [31:0] held_q[$];      // sorted, smallest first
    t_out_word          expected_q[$];
    logic [CAP_W-1:0]   capacity;
    int                 mismatches;
    int                 full_refusals;
    int                 empty_refusals;

    initial begin
        mismatches       = 0;
        full_refusals    = 0;
        empty_refusals   = 0;
        capacity         = CAP_RESET;
    end

    function automatic t_out_word apply_queue_op(t_in_word w);
        t_out_word          r;
        logic signed [31:0] v;
        int                 room;
        int                 pos;
        r.out_value = '0;
        r.status    = ST_DONE;
        v           = w.value;
        room        = (capacity > DEPTH) ? DEPTH : int'(capacity);
        if (w.op == OP_INSERT) begin
            if (held_q.size() >= room) begin
                r.status = ST_FULL;
                full_refusals++;
            end else begin
                // ties go behind every equal entry
                pos = held_q.size();
                while (pos > 0 && held_q[pos-1] > v) pos--;
                held_q.insert(pos, v);
            end
        end else if (held_q.size() == 0) begin
            r.status = ST_EMPTY;
            empty_refusals++;
        end else begin
            r.out_value = held_q.pop_front();
        end
        r.fill_count = FILL_W'(held_q.size());
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            held_q.delete();
            expected_q.delete();
            capacity = CAP_RESET;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr[2] == REG_CAPACITY)
                capacity = i_pwdata[CAP_W-1:0];

            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $error("result word with nothing expected: value %0d status %0d fill %0d",
                           $signed(i_out_word.out_value), i_out_word.status,
                           i_out_word.fill_count);
                    mismatches++;
                end else begin
                    want = expected_q.pop_front();
                    if (i_out_word.out_value !== want.out_value) begin
                        $error("out_value: expected %0d, got %0d",
                               $signed(want.out_value), $signed(i_out_word.out_value));
                        mismatches++;
                    end
                    if (i_out_word.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status,
                               i_out_word.status);
                        mismatches++;
                    end
                    if (i_out_word.fill_count !== want.fill_count) begin
                        $error("fill_count: expected %0d, got %0d", want.fill_count,
                               i_out_word.fill_count);
                        mismatches++;
                    end
                end
            end

            if (i_in_valid && !i_in_stall)
                expected_q.push_back(apply_queue_op(i_in_word));
        end
        o_mismatches     <= mismatches;
        o_pending        <= expected_q.size();
        o_full_refusals  <= full_refusals;
        o_empty_refusals <= empty_refusals;
    end

endmodule

FILE: tb/tb_top.sv
module tb_top;
    import smpq_pkg::*;

    localparam logic [2:0] ADDR_CAPACITY = {REG_CAPACITY, 2'b00};
    localparam logic [2:0] ADDR_UNMAPPED = 3'd4;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        in_valid = 1'b0;
    t_in_word    in_word  = '0;
    logic        out_stall = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;

    logic        in_stall;
    logic        out_valid;
    t_out_word   out_word;
    logic [31:0] prdata;
    logic        pready;

    int          mismatches;
    int          pending;
    int          full_refusals;
    int          empty_refusals;
    int          words_sent = 0;
    bit          idle_on = 1'b1;

    sorted_min_priority_queue dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    smpq_checker checker_i (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_in_word        (in_word),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_out_word       (out_word),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_pready         (pready),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .o_mismatches     (mismatches),
        .o_pending        (pending),
        .o_full_refusals  (full_refusals),
        .o_empty_refusals (empty_refusals)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    initial begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // result-side backpressure in random bursts
    initial begin
        @(posedge clk);
        forever begin
            if (idle_on && $urandom_range(0, 4) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end else begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    task automatic send_word(input logic op, input logic signed [31:0] v);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= '{op: op, value: v};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        words_sent++;
    endtask

    // stop sending and wait until every expected result word is back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic signed [31:0] pick_value();
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = $urandom();
            5, 6, 7:       v = 32'($urandom_range(0, 16)) - 32'd8;   // many ties
            8:             v = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default:       v = $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 3)
                                                    : 32'h8000_0000 + $urandom_range(0, 3);
        endcase
        return v;
    endfunction

    task automatic run_phase(input int cap, input int n_words, input int insert_pct,
                             input bit with_idle);
        idle_on = with_idle;
        write_reg(ADDR_CAPACITY, cap);
        repeat (n_words)
            send_word(($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE,
                      pick_value());
        drain();
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // capacity at its reset value: empty remove, extremes, ties, drain past empty
        send_word(OP_REMOVE, $urandom());
        send_word(OP_INSERT, 32'sd0);
        send_word(OP_INSERT, 32'h7fff_ffff);
        send_word(OP_INSERT, 32'h8000_0000);
        send_word(OP_INSERT, -32'sd1);
        send_word(OP_INSERT, 32'sd5);
        send_word(OP_INSERT, 32'sd5);
        send_word(OP_INSERT, 32'h8000_0000);
        repeat (8) send_word(OP_REMOVE, $urandom());
        drain();

        // single-entry queue
        write_reg(ADDR_CAPACITY, 32'd1);
        send_word(OP_INSERT, 32'sd7);
        send_word(OP_INSERT, 32'sd8);
        send_word(OP_REMOVE, $urandom());
        send_word(OP_REMOVE, $urandom());
        drain();

        // zero capacity refuses every insert
        write_reg(ADDR_CAPACITY, 32'd0);
        send_word(OP_INSERT, 32'sd3);
        send_word(OP_REMOVE, $urandom());
        drain();

        // unmapped register must not disturb capacity
        write_reg(ADDR_UNMAPPED, 32'd1);
        run_phase(127, 90, 85, 1'b1);    // saturates to full depth, fills up
        run_phase(5, 60, 50, 1'b1);      // capacity now below the fill count
        run_phase(3, 80, 55, 1'b1);
        run_phase(64, 120, 60, 1'b1);
        run_phase(1, 50, 50, 1'b1);
        run_phase(100, 80, 40, 1'b1);
        run_phase(64, 70, 55, 1'b0);     // back to back, no stalls

        repeat (5) @(posedge clk);
        $display("Sent %0d words across capacities 0, 1, 3, 5, 64, 100 and 127,",
                 words_sent);
        $display("with %0d inserts refused as full and %0d removes refused as empty.",
                 full_refusals, empty_refusals);
        if (mismatches == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/smpq_pkg.sv
rtl/smpq_cell.sv
rtl/sorted_min_priority_queue.sv
tb/smpq_checker.sv
tb/tb_top.sv
